@@ hw/rtl/fpm_pkg.sv @@
// Shared constants and types of the floor projection mapper.
`timescale 1ns / 1ps

package fpm_pkg;

    localparam int VIEW_MID_X    = 160;
    localparam int VIEW_MID_Y    = 120;
    localparam int HORIZON_LIFT  = 100;
    localparam int MAP_MAX       = 4096;

    localparam int PIX_W       = 10;
    localparam int POS_W       = 21;
    localparam int TRIG_W      = 16;
    localparam int SCALE_W     = 16;
    localparam int SIZE_W      = 13;
    localparam int TEX_W       = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 21;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;

    localparam int DX_W       = PIX_W + 1;
    localparam int DY_W       = PIX_W + 2;
    localparam int DEPTH_W    = PIX_W;
    localparam int ROT_W      = 28;
    localparam int PROD_W     = 44;
    localparam int FRAC_SHIFT = 14;
    localparam int QUO_W      = 28;
    localparam int DIV_STAGES = QUO_W;
    localparam int LOC_W      = 30;
    localparam int TEX_FRAC   = 8;
    localparam int LIM_W      = TEX_W + TEX_FRAC;
    localparam int ROUND_HALF = 1 << (TEX_FRAC - 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CAMERA_X    = 3'd0,
        REG_CAMERA_Z    = 3'd1,
        REG_SIN_ANGLE   = 3'd2,
        REG_COS_ANGLE   = 3'd3,
        REG_WORLD_SCALE = 3'd4,
        REG_MAP_WIDTH   = 3'd5,
        REG_MAP_HEIGHT  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic             above;
    } pix_tag_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] rem;
        logic [QUO_W-1:0]   work;
    } div_state_t;

endpackage

@@ hw/rtl/floor_projection_mapper.sv @@
// Top level of the floor projection mapper: pixel to floor texel pipeline.
//
//   channel  direction  words                          fields (lowest bit first)
//   s_       in         one screen pixel               tdata: pixel_x, pixel_y
//   m_       out        one texel address per pixel    tdata: out_x, out_y, map_col,
//                                                      map_row; tuser: outside
//   cfg_     in         register write                 cfg_index, cfg_data
//
// One word is accepted per cycle unless the output word waits on m_tready.
// The pipeline holds a 28-stage restoring divider that divides by depth.
// aresetn is synchronous; it clears the valid bits and resets the configuration registers to their defaults.
// The whole pipeline holds while the output word waits on m_tready.
`timescale 1ns / 1ps

module floor_projection_mapper (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fpm_pkg::S_TDATA_W-1:0]     s_tdata,   // pixel_x, pixel_y
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fpm_pkg::M_TDATA_W-1:0]     m_tdata,   // out_x, out_y, map_col, map_row
    output logic                              m_tuser,   // outside
    input  logic                              cfg_wr_en,
    input  logic [fpm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fpm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fpm_pkg::*;

    logic signed [POS_W-1:0]   camera_x_reg;
    logic signed [POS_W-1:0]   camera_z_reg;
    logic signed [TRIG_W-1:0]  sin_angle_reg;
    logic signed [TRIG_W-1:0]  cos_angle_reg;
    logic [SCALE_W-1:0]        world_scale_reg;
    logic [SIZE_W-1:0]         map_width_reg;
    logic [SIZE_W-1:0]         map_height_reg;

    logic                      advance;

    logic [PIX_W-1:0]          in_x;
    logic [PIX_W-1:0]          in_y;
    logic signed [DX_W-1:0]    dx_a;
    logic signed [DY_W-1:0]    dy_a;
    logic [DEPTH_W-1:0]        dz_a;
    logic signed [ROT_W-1:0]   pxc_next;
    logic signed [ROT_W-1:0]   pys_next;
    logic signed [ROT_W-1:0]   pyc_next;
    logic signed [ROT_W-1:0]   pxs_next;

    logic                      valid_a_reg;
    pix_tag_t                  tag_a_reg;
    logic [DEPTH_W-1:0]        dz_a_reg;
    logic signed [ROT_W-1:0]   pxc_a_reg;
    logic signed [ROT_W-1:0]   pys_a_reg;
    logic signed [ROT_W-1:0]   pyc_a_reg;
    logic signed [ROT_W-1:0]   pxs_a_reg;

    logic                      valid_b_reg;
    pix_tag_t                  tag_b_reg;
    logic [DEPTH_W-1:0]        dz_b_reg;
    logic signed [ROT_W-1:0]   rx_b_reg;
    logic signed [ROT_W-1:0]   ry_b_reg;

    logic signed [PROD_W-1:0]  nx_next;
    logic signed [PROD_W-1:0]  ny_next;
    logic                      valid_c_reg;
    pix_tag_t                  tag_c_reg;
    logic [DEPTH_W-1:0]        dz_c_reg;
    logic signed [PROD_W-1:0]  nx_c_reg;
    logic signed [PROD_W-1:0]  ny_c_reg;

    logic                      valid_d_reg;
    pix_tag_t                  tag_d_reg;
    logic [DEPTH_W-1:0]        dz_d_reg;
    logic                      neg_x_d_reg;
    logic                      neg_y_d_reg;
    logic [QUO_W-1:0]          ux_d_reg;
    logic [QUO_W-1:0]          uy_d_reg;

    logic                      dv_valid_reg [DIV_STAGES];
    pix_tag_t                  dv_tag_reg   [DIV_STAGES];
    logic [DEPTH_W-1:0]        dv_dz_reg    [DIV_STAGES];
    logic                      dv_neg_x_reg [DIV_STAGES];
    logic                      dv_neg_y_reg [DIV_STAGES];
    div_state_t                dv_x_reg     [DIV_STAGES];
    div_state_t                dv_y_reg     [DIV_STAGES];
    div_state_t                dv_x_next    [DIV_STAGES];
    div_state_t                dv_y_next    [DIV_STAGES];

    logic [QUO_W:0]            qx;
    logic [QUO_W:0]            qy;
    logic signed [LOC_W-1:0]   loc_x_next;
    logic signed [LOC_W-1:0]   loc_y_next;
    logic                      valid_e_reg;
    pix_tag_t                  tag_e_reg;
    logic signed [LOC_W-1:0]   loc_x_e_reg;
    logic signed [LOC_W-1:0]   loc_y_e_reg;

    logic [SIZE_W-1:0]         w_clamp;
    logic [SIZE_W-1:0]         h_clamp;
    logic [SIZE_W-1:0]         w_m1;
    logic [SIZE_W-1:0]         h_m1;
    logic [LIM_W-1:0]          lim_x;
    logic [LIM_W-1:0]          lim_y;
    logic                      on_map;
    logic [LIM_W-1:0]          rnd_x;
    logic [LIM_W-1:0]          rnd_y;
    logic [SIZE_W-1:0]         row_full;

    logic                      m_tvalid_reg;
    logic [PIX_W-1:0]          out_x_reg;
    logic [PIX_W-1:0]          out_y_reg;
    logic [TEX_W-1:0]          map_col_reg;
    logic [TEX_W-1:0]          map_row_reg;
    logic                      outside_reg;

    function automatic div_state_t div_step(input div_state_t st,
                                            input logic [DEPTH_W-1:0] dz);
        logic [DEPTH_W:0] trial;
        div_state_t       r;
        trial = {st.rem, st.work[QUO_W-1]};
        if (trial >= {1'b0, dz}) begin
            r.rem  = DEPTH_W'(trial - {1'b0, dz});
            r.work = {st.work[QUO_W-2:0], 1'b1};
        end else begin
            r.rem  = trial[DEPTH_W-1:0];
            r.work = {st.work[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            camera_x_reg    <= '0;
            camera_z_reg    <= '0;
            sin_angle_reg   <= '0;
            cos_angle_reg   <= 16'sd16384;
            world_scale_reg <= 16'd256;
            map_width_reg   <= 13'd1024;
            map_height_reg  <= 13'd1024;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_CAMERA_X:    camera_x_reg    <= cfg_data[POS_W-1:0];
                REG_CAMERA_Z:    camera_z_reg    <= cfg_data[POS_W-1:0];
                REG_SIN_ANGLE:   sin_angle_reg   <= cfg_data[TRIG_W-1:0];
                REG_COS_ANGLE:   cos_angle_reg   <= cfg_data[TRIG_W-1:0];
                REG_WORLD_SCALE: world_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_MAP_WIDTH:   map_width_reg   <= cfg_data[SIZE_W-1:0];
                REG_MAP_HEIGHT:  map_height_reg  <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // Offsets from the screen center, the lifted row and the four rotation products.
    always_comb begin
        in_x = s_tdata[PIX_W-1:0];
        in_y = s_tdata[2*PIX_W-1:PIX_W];
        dx_a = DX_W'($signed({1'b0, in_x}) - VIEW_MID_X);
        dy_a = DY_W'($signed({2'b00, in_y}) + HORIZON_LIFT);
        dz_a = DEPTH_W'(in_y - VIEW_MID_Y);
        if (dz_a == '0) begin
            dz_a = DEPTH_W'(1);
        end
        pxc_next = dx_a * cos_angle_reg;
        pys_next = dy_a * sin_angle_reg;
        pyc_next = dy_a * cos_angle_reg;
        pxs_next = dx_a * sin_angle_reg;
    end

    always_comb begin
        nx_next = rx_b_reg * $signed({1'b0, world_scale_reg});
        ny_next = ry_b_reg * $signed({1'b0, world_scale_reg});
    end

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                dv_x_next[k] = div_step('{rem: '0, work: ux_d_reg}, dz_d_reg);
                dv_y_next[k] = div_step('{rem: '0, work: uy_d_reg}, dz_d_reg);
            end else begin
                dv_x_next[k] = div_step(dv_x_reg[k-1], dv_dz_reg[k-1]);
                dv_y_next[k] = div_step(dv_y_reg[k-1], dv_dz_reg[k-1]);
            end
        end
    end

    // A negative dividend was divided as its complement; complementing the
    // quotient gives the floor of the signed quotient.
    always_comb begin
        qx = dv_neg_x_reg[DIV_STAGES-1] ? ~{1'b0, dv_x_reg[DIV_STAGES-1].work}
                                        :  {1'b0, dv_x_reg[DIV_STAGES-1].work};
        qy = dv_neg_y_reg[DIV_STAGES-1] ? ~{1'b0, dv_y_reg[DIV_STAGES-1].work}
                                        :  {1'b0, dv_y_reg[DIV_STAGES-1].work};
        loc_x_next = $signed({{(LOC_W-QUO_W-1){qx[QUO_W]}}, qx})
                   + $signed({{(LOC_W-POS_W){camera_x_reg[POS_W-1]}}, camera_x_reg});
        loc_y_next = $signed({{(LOC_W-QUO_W-1){qy[QUO_W]}}, qy})
                   + $signed({{(LOC_W-POS_W){camera_z_reg[POS_W-1]}}, camera_z_reg});
    end

    always_comb begin
        w_clamp = (map_width_reg > SIZE_W'(MAP_MAX)) ? SIZE_W'(MAP_MAX) : map_width_reg;
        h_clamp = (map_height_reg > SIZE_W'(MAP_MAX)) ? SIZE_W'(MAP_MAX) : map_height_reg;
        w_m1    = w_clamp - SIZE_W'(1);
        h_m1    = h_clamp - SIZE_W'(1);
        lim_x   = {w_m1[TEX_W-1:0], {TEX_FRAC{1'b0}}};
        lim_y   = {h_m1[TEX_W-1:0], {TEX_FRAC{1'b0}}};
        on_map  = !tag_e_reg.above && (w_clamp != '0) && (h_clamp != '0)
               && !loc_x_e_reg[LOC_W-1] && !loc_y_e_reg[LOC_W-1]
               && (loc_x_e_reg[LOC_W-2:0] <= {{(LOC_W-1-LIM_W){1'b0}}, lim_x})
               && (loc_y_e_reg[LOC_W-2:0] <= {{(LOC_W-1-LIM_W){1'b0}}, lim_y});
        rnd_x    = loc_x_e_reg[LIM_W-1:0] + LIM_W'(ROUND_HALF);
        rnd_y    = loc_y_e_reg[LIM_W-1:0] + LIM_W'(ROUND_HALF);
        row_full = h_m1 - {1'b0, rnd_y[LIM_W-1:TEX_FRAC]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg  <= 1'b0;
            valid_b_reg  <= 1'b0;
            valid_c_reg  <= 1'b0;
            valid_d_reg  <= 1'b0;
            valid_e_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++) begin
                dv_valid_reg[k] <= 1'b0;
            end
        end else if (advance) begin
            valid_a_reg     <= s_tvalid;
            valid_b_reg     <= valid_a_reg;
            valid_c_reg     <= valid_b_reg;
            valid_d_reg     <= valid_c_reg;
            dv_valid_reg[0] <= valid_d_reg;
            for (int k = 1; k < DIV_STAGES; k++) begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
            valid_e_reg  <= dv_valid_reg[DIV_STAGES-1];
            m_tvalid_reg <= valid_e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tag_a_reg <= '{pixel_x: in_x, pixel_y: in_y,
                           above: (in_y < PIX_W'(VIEW_MID_Y))};
            dz_a_reg  <= dz_a;
            pxc_a_reg <= pxc_next;
            pys_a_reg <= pys_next;
            pyc_a_reg <= pyc_next;
            pxs_a_reg <= pxs_next;

            tag_b_reg <= tag_a_reg;
            dz_b_reg  <= dz_a_reg;
            rx_b_reg  <= pxc_a_reg + pys_a_reg;
            ry_b_reg  <= pyc_a_reg - pxs_a_reg;

            tag_c_reg <= tag_b_reg;
            dz_c_reg  <= dz_b_reg;
            nx_c_reg  <= nx_next;
            ny_c_reg  <= ny_next;

            tag_d_reg   <= tag_c_reg;
            dz_d_reg    <= dz_c_reg;
            neg_x_d_reg <= nx_c_reg[PROD_W-1];
            neg_y_d_reg <= ny_c_reg[PROD_W-1];
            ux_d_reg    <= nx_c_reg[PROD_W-1] ? ~nx_c_reg[FRAC_SHIFT +: QUO_W]
                                              :  nx_c_reg[FRAC_SHIFT +: QUO_W];
            uy_d_reg    <= ny_c_reg[PROD_W-1] ? ~ny_c_reg[FRAC_SHIFT +: QUO_W]
                                              :  ny_c_reg[FRAC_SHIFT +: QUO_W];

            for (int k = 0; k < DIV_STAGES; k++) begin
                dv_x_reg[k] <= dv_x_next[k];
                dv_y_reg[k] <= dv_y_next[k];
                if (k == 0) begin
                    dv_tag_reg[k]   <= tag_d_reg;
                    dv_dz_reg[k]    <= dz_d_reg;
                    dv_neg_x_reg[k] <= neg_x_d_reg;
                    dv_neg_y_reg[k] <= neg_y_d_reg;
                end else begin
                    dv_tag_reg[k]   <= dv_tag_reg[k-1];
                    dv_dz_reg[k]    <= dv_dz_reg[k-1];
                    dv_neg_x_reg[k] <= dv_neg_x_reg[k-1];
                    dv_neg_y_reg[k] <= dv_neg_y_reg[k-1];
                end
            end

            tag_e_reg   <= dv_tag_reg[DIV_STAGES-1];
            loc_x_e_reg <= loc_x_next;
            loc_y_e_reg <= loc_y_next;

            out_x_reg   <= tag_e_reg.pixel_x;
            out_y_reg   <= tag_e_reg.pixel_y;
            outside_reg <= !on_map;
            map_col_reg <= on_map ? rnd_x[LIM_W-1:TEX_FRAC] : '0;
            map_row_reg <= on_map ? row_full[TEX_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = outside_reg;
    assign m_tdata  = {{(M_TDATA_W-2*PIX_W-2*TEX_W){1'b0}},
                       map_row_reg, map_col_reg, out_y_reg, out_x_reg};

`ifndef ASSERT_OFF
    a_above_is_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_y_reg < PIX_W'(VIEW_MID_Y)) |-> m_tuser)
        else $error("pixel above the horizon was mapped inside the floor");

    a_col_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> ({1'b0, map_col_reg} <= w_m1) && (w_clamp != '0))
        else $error("texel column beyond the map width");

    a_tail_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_e_reg && advance |=> m_tvalid)
        else $error("word lost between the last stage and the output register");
`endif

endmodule
